// File: rtl/cmmd_pkg.sv
package cmmd_pkg;

   localparam int ADDR_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int TARGET_W   = 4;
   localparam int OFFSET_W   = 15;
   localparam int RAM_IDX_W  = 13;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Target codes as seen on the result channel.
   localparam logic [TARGET_W-1:0] TGT_NONE = 4'd0;
   localparam logic [TARGET_W-1:0] TGT_BOOT = 4'd1;
   localparam logic [TARGET_W-1:0] TGT_ROM0 = 4'd2;
   localparam logic [TARGET_W-1:0] TGT_ROMN = 4'd3;
   localparam logic [TARGET_W-1:0] TGT_VRAM = 4'd4;
   localparam logic [TARGET_W-1:0] TGT_ERAM = 4'd5;
   localparam logic [TARGET_W-1:0] TGT_OAM  = 4'd6;
   localparam logic [TARGET_W-1:0] TGT_VIO  = 4'd7;
   localparam logic [TARGET_W-1:0] TGT_BANK = 4'd8;

   localparam logic [ADDR_W-1:0] ADDR_BOOT_EXIT = 16'h0100;
   localparam logic [ADDR_W-1:0] ADDR_IF        = 16'hFF0F;
   localparam logic [ADDR_W-1:0] ADDR_IE        = 16'hFFFF;
   localparam logic [ADDR_W-1:0] ADDR_OAM_END   = 16'hFEA0;
   localparam logic [ADDR_W-1:0] ADDR_VIO_LO    = 16'hFF40;
   localparam logic [ADDR_W-1:0] ADDR_VIO_HI    = 16'hFF4C;

   // What the back end has to do with an item beyond forwarding it.
   typedef enum logic [2:0] {
      KIND_NONE = 3'd0,
      KIND_WRAM = 3'd1,
      KIND_HRAM = 3'd2,
      KIND_IF   = 3'd3,
      KIND_IE   = 3'd4
   } kind_type;

   typedef struct packed {
      logic                   is_write;
      logic [TARGET_W-1:0]    target;
      logic [OFFSET_W-1:0]    offset;
      logic [BYTE_W-1:0]      data;
      kind_type               kind;
      logic [RAM_IDX_W-1:0]   ram_idx;
   } entry_type;

endpackage

// File: rtl/cmmd_front.sv
module cmmd_front import cmmd_pkg::*; #(
   parameter int HIGH_RAM_BYTES = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic               opcode,
   input  logic [ADDR_W-1:0]  address,
   input  logic [BYTE_W-1:0]  write_data,
   input  logic               queue_ready,
   input  logic               hold,
   output logic               push,
   output entry_type          entry
);

   localparam logic [7:0] HR_LIMIT = 8'(HIGH_RAM_BYTES);

   logic overlay_ff;
   logic overlay_in;

   assign in_ready = queue_ready && !hold;
   assign push     = in_valid && in_ready;

   always_comb begin
      entry          = '0;
      entry.is_write = opcode;
      entry.data     = opcode ? write_data : '0;
      entry.kind     = KIND_NONE;
      entry.target   = TGT_NONE;
      entry.offset   = '0;
      entry.ram_idx  = address[RAM_IDX_W-1:0];
      overlay_in     = overlay_ff;
      priority if (!address[15]) begin
         if (opcode) begin
            entry.target = TGT_BANK;
            entry.offset = address[OFFSET_W-1:0];
         end else if (!address[14]) begin
            if (overlay_ff && address[15:8] == 8'h00) begin
               entry.target = TGT_BOOT;
            end else begin
               entry.target = TGT_ROM0;
               if (address == ADDR_BOOT_EXIT && push) begin
                  overlay_in = 1'b0;
               end
            end
            entry.offset = address[OFFSET_W-1:0];
         end else begin
            entry.target = TGT_ROMN;
            entry.offset = {1'b0, address[13:0]};
         end
      end else if (address[15:13] == 3'b100) begin
         entry.target = TGT_VRAM;
         entry.offset = {2'b00, address[12:0]};
      end else if (address[15:13] == 3'b101) begin
         entry.target = TGT_ERAM;
         entry.offset = {2'b00, address[12:0]};
      end else if (address[15:9] != 7'h7F) begin
         // Work RAM and its echo share the low 13 address bits.
         entry.kind = KIND_WRAM;
      end else if (address[15:8] == 8'hFE) begin
         if (address < ADDR_OAM_END) begin
            entry.target = TGT_OAM;
            entry.offset = {7'd0, address[7:0]};
         end
      end else if (!address[7]) begin
         if (address == ADDR_IF) begin
            entry.kind = KIND_IF;
         end else if (address >= ADDR_VIO_LO && address < ADDR_VIO_HI) begin
            entry.target = TGT_VIO;
            entry.offset = {11'd0, address[3:0]};
         end
      end else if (address == ADDR_IE) begin
         entry.kind = KIND_IE;
      end else if ({1'b0, address[6:0]} < HR_LIMIT) begin
         entry.kind = KIND_HRAM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overlay_ff <= 1'b1;
      end else begin
         overlay_ff <= overlay_in;
      end
   end

endmodule

// File: rtl/cmmd_queue.sv
module cmmd_queue import cmmd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  entry_type          push_entry,
   output logic               push_ready,
   input  logic               pop,
   output logic               pop_valid,
   output entry_type          pop_entry,
   output logic [QCNT_W-1:0]  count
);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/cmmd_back.sv
module cmmd_back import cmmd_pkg::*; #(
   parameter int WORK_RAM_BYTES = 8192,
   parameter int HIGH_RAM_BYTES = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  entry_type            head,
   output logic                 pop,
   output logic                 clear_busy,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [TARGET_W-1:0]  out_target,
   output logic [OFFSET_W-1:0]  out_offset,
   output logic [BYTE_W-1:0]    out_data,
   output logic                 out_is_write
);

   localparam int WR_AW = $clog2(WORK_RAM_BYTES);
   localparam int HR_AW = $clog2(HIGH_RAM_BYTES);

   typedef enum logic [1:0] {
      SRC_DATA = 2'd0,
      SRC_WRAM = 2'd1,
      SRC_HRAM = 2'd2
   } src_type;

   logic [BYTE_W-1:0]    wram_ff [WORK_RAM_BYTES];
   logic [BYTE_W-1:0]    hram_ff [HIGH_RAM_BYTES];
   logic [HIGH_RAM_BYTES-1:0] hram_vld_ff, hram_vld_in;

   logic                 clr_busy_ff, clr_busy_in;
   logic [WR_AW-1:0]     clr_ptr_ff, clr_ptr_in;

   logic [BYTE_W-1:0]    irq_flags_ff, irq_flags_in;
   logic [BYTE_W-1:0]    irq_enable_ff, irq_enable_in;

   logic [BYTE_W-1:0]    wram_rd_ff;
   logic [BYTE_W-1:0]    hram_rd_ff;
   logic                 hram_rd_vld_ff;

   logic                 s1_valid_ff, s1_valid_in;
   logic [TARGET_W-1:0]  s1_target_ff, s1_target_in;
   logic [OFFSET_W-1:0]  s1_offset_ff, s1_offset_in;
   logic [BYTE_W-1:0]    s1_data_ff, s1_data_in;
   logic                 s1_write_ff, s1_write_in;
   src_type              s1_src_ff, s1_src_in;

   logic                 wram_we;
   logic [WR_AW-1:0]     wram_waddr;
   logic [BYTE_W-1:0]    wram_wdata;
   logic                 wram_re;
   logic                 hram_we;
   logic                 hram_re;
   logic [WR_AW-1:0]     wram_idx;
   logic [HR_AW-1:0]     hram_idx;

   assign pop        = head_valid && !clr_busy_ff && (!s1_valid_ff || out_ready);
   assign clear_busy = clr_busy_ff;
   assign wram_idx   = head.ram_idx[WR_AW-1:0];
   assign hram_idx   = head.ram_idx[HR_AW-1:0];

   assign wram_re = pop && head.kind == KIND_WRAM && !head.is_write;
   assign hram_re = pop && head.kind == KIND_HRAM && !head.is_write;
   assign hram_we = pop && head.kind == KIND_HRAM && head.is_write;

   // The clearing pass owns the work RAM write port until it finishes.
   always_comb begin
      if (clr_busy_ff) begin
         wram_we    = 1'b1;
         wram_waddr = clr_ptr_ff;
         wram_wdata = '0;
      end else begin
         wram_we    = pop && head.kind == KIND_WRAM && head.is_write;
         wram_waddr = wram_idx;
         wram_wdata = head.data;
      end
   end

   always_comb begin
      clr_ptr_in  = clr_ptr_ff + 1'b1;
      clr_busy_in = clr_busy_ff && (clr_ptr_ff != {WR_AW{1'b1}});
      hram_vld_in = hram_vld_ff;
      if (hram_we) begin
         hram_vld_in[hram_idx] = 1'b1;
      end
      irq_flags_in  = irq_flags_ff;
      irq_enable_in = irq_enable_ff;
      if (pop && head.is_write && head.kind == KIND_IF) begin
         irq_flags_in = head.data;
      end
      if (pop && head.is_write && head.kind == KIND_IE) begin
         irq_enable_in = head.data;
      end
   end

   always_comb begin
      s1_valid_in  = pop ? 1'b1 : (s1_valid_ff && !out_ready);
      s1_target_in = head.target;
      s1_offset_in = head.offset;
      s1_write_in  = head.is_write;
      s1_data_in   = head.data;
      s1_src_in    = SRC_DATA;
      if (!head.is_write) begin
         unique case (head.kind)
            KIND_WRAM: s1_src_in  = SRC_WRAM;
            KIND_HRAM: s1_src_in  = SRC_HRAM;
            KIND_IF:   s1_data_in = irq_flags_ff;
            KIND_IE:   s1_data_in = irq_enable_ff;
            default:   s1_src_in  = SRC_DATA;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff   <= 1'b1;
         clr_ptr_ff    <= '0;
         hram_vld_ff   <= '0;
         irq_flags_ff  <= '0;
         irq_enable_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         clr_busy_ff   <= clr_busy_in;
         clr_ptr_ff    <= clr_busy_ff ? clr_ptr_in : clr_ptr_ff;
         hram_vld_ff   <= hram_vld_in;
         irq_flags_ff  <= irq_flags_in;
         irq_enable_ff <= irq_enable_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_target_ff <= s1_target_in;
         s1_offset_ff <= s1_offset_in;
         s1_write_ff  <= s1_write_in;
         s1_data_ff   <= s1_data_in;
         s1_src_ff    <= s1_src_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wram_we) begin
         wram_ff[wram_waddr] <= wram_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (wram_re) begin
         wram_rd_ff <= wram_ff[wram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (hram_we) begin
         hram_ff[hram_idx] <= head.data;
      end
   end

   always_ff @(posedge clock) begin
      if (hram_re) begin
         hram_rd_ff     <= hram_ff[hram_idx];
         hram_rd_vld_ff <= hram_vld_ff[hram_idx];
      end
   end

   assign out_valid    = s1_valid_ff;
   assign out_target   = s1_target_ff;
   assign out_offset   = s1_offset_ff;
   assign out_is_write = s1_write_ff;

   always_comb begin
      unique case (s1_src_ff)
         SRC_WRAM: out_data = wram_rd_ff;
         SRC_HRAM: out_data = hram_rd_vld_ff ? hram_rd_ff : '0;
         default:  out_data = s1_data_ff;
      endcase
   end

endmodule

// File: rtl/console_memory_map_decoder_core.sv
// Memory map decoder for a 16-bit console bus.
// The request channel (req_) carries one bus access per item: req_tuser is the
// access kind (0 read, 1 write), req_tdata the address and the write byte.
// The response channel (rsp_) returns exactly one item per request, in order:
// the external target code, the local offset and the data byte, with the
// write flag on rsp_tuser. Work RAM, high RAM and the interrupt registers are
// served here; the other regions are only routed.
// An accepted request is decoded into the request queue, then executed against the
// local RAMs into the response register, from which it appears on rsp_. One item
// per cycle is sustained in both directions while rsp_tready stays high and no sweep
// runs; the work RAM, with one write and one read port, is accessed at most once per item.
// After reset, req_tready stays low while the work RAM is swept to zero; high RAM
// uses valid bits and needs no sweep.
// When the receiver holds rsp_tready low, the response register keeps its item
// and the four-entry queue keeps filling; req_tready drops once it is full.
module console_memory_map_decoder_core import cmmd_pkg::*; #(
   parameter int WORK_RAM_BYTES = 8192,
   parameter int HIGH_RAM_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // address[15:0], write_data[23:16]
   input  logic [0:0]  req_tuser,  // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // target[3:0], offset[18:4], data[26:19], zero[31:27]
   output logic [0:0]  rsp_tuser   // is_write[0]
);

   entry_type            push_entry;
   entry_type            head_entry;
   logic                 push;
   logic                 queue_ready;
   logic                 head_valid;
   logic                 pop;
   logic                 clear_busy;
   logic [QCNT_W-1:0]    queue_count;
   logic [TARGET_W-1:0]  rsp_target;
   logic [OFFSET_W-1:0]  rsp_offset;
   logic [BYTE_W-1:0]    rsp_data;
   logic                 rsp_is_write;

   cmmd_front #(
      .HIGH_RAM_BYTES (HIGH_RAM_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .opcode      (req_tuser[0]),
      .address     (req_tdata[15:0]),
      .write_data  (req_tdata[23:16]),
      .queue_ready (queue_ready),
      .hold        (clear_busy),
      .push        (push),
      .entry       (push_entry)
   );

   cmmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (head_valid),
      .pop_entry  (head_entry),
      .count      (queue_count)
   );

   cmmd_back #(
      .WORK_RAM_BYTES (WORK_RAM_BYTES),
      .HIGH_RAM_BYTES (HIGH_RAM_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head_entry),
      .pop          (pop),
      .clear_busy   (clear_busy),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_target   (rsp_target),
      .out_offset   (rsp_offset),
      .out_data     (rsp_data),
      .out_is_write (rsp_is_write)
   );

   assign rsp_tdata = {5'd0, rsp_data, rsp_offset, rsp_target};
   assign rsp_tuser = rsp_is_write;

   // No request may be taken while the work RAM sweep is running.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !(req_tvalid && req_tready))
      else $error("request accepted during work RAM clear");

   // The queue never holds more than its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("request queue overflow");

   // Internal accesses carry no offset.
   a_internal_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_target == TGT_NONE) |-> rsp_offset == '0)
      else $error("internal response with nonzero offset");

   // Boot ROM accesses stay inside the first 256 bytes.
   a_boot_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_target == TGT_BOOT) |-> (rsp_offset[14:8] == '0 && !rsp_is_write))
      else $error("boot ROM response out of range");

endmodule

// File: sim/tb_console_memory_map_decoder_core.sv
`timescale 1ns / 100ps
module tb_console_memory_map_decoder_core;
   import cmmd_pkg::*;

   localparam int WRAM_BYTES  = 8192;
   localparam int HRAM_BYTES  = 128;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_GAP     = 24;
   localparam int SETTLE      = 16;
   localparam int PHASE_ITEMS = 370;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [ADDR_W-1:0] ADDR_VRAM  = 16'h8000;
   localparam logic [ADDR_W-1:0] ADDR_ERAM  = 16'hA000;
   localparam logic [ADDR_W-1:0] ADDR_WRAM  = 16'hC000;
   localparam logic [ADDR_W-1:0] ADDR_ECHO  = 16'hE000;
   localparam logic [ADDR_W-1:0] ADDR_OAM   = 16'hFE00;
   localparam logic [ADDR_W-1:0] ADDR_IO    = 16'hFF00;
   localparam logic [ADDR_W-1:0] ADDR_HRAM  = 16'hFF80;
   localparam logic [ADDR_W-1:0] ADDR_ROMN  = 16'h4000;

   typedef struct {
      logic [ADDR_W-1:0]   address;
      logic [TARGET_W-1:0] target;
      logic [OFFSET_W-1:0] offset;
      logic [BYTE_W-1:0]   data;
      logic                is_write;
   } bus_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // address[15:0], write_data[23:16]
   logic [0:0]  req_tuser  = '0;  // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // target[3:0], offset[18:4], data[26:19], zero[31:27]
   logic [0:0]  rsp_tuser;        // is_write[0]

   // Shadow copy of the block's local storage.
   logic [BYTE_W-1:0] wram_shadow [WRAM_BYTES];
   logic [BYTE_W-1:0] hram_shadow [128];
   logic [BYTE_W-1:0] irq_enable_shadow;
   logic [BYTE_W-1:0] irq_flags_shadow;
   logic              overlay_shadow;

   bus_result_type pending_results[$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int cycle_count    = 0;
   int mismatch_count = 0;
   int results_seen   = 0;
   int reads_sent     = 0;
   int writes_sent    = 0;
   int boot_reads     = 0;

   console_memory_map_decoder_core #(
      .WORK_RAM_BYTES(WRAM_BYTES),
      .HIGH_RAM_BYTES(HRAM_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Decodes one access against the map and updates the shadow state.
   function automatic bus_result_type decode_access(input logic op,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [BYTE_W-1:0] wdata);
      bus_result_type res;
      logic [6:0]     hidx;
      res.address  = addr;
      res.is_write = op;
      res.data     = (op == OP_WRITE) ? wdata : '0;
      res.target   = TGT_NONE;
      res.offset   = '0;
      if (addr < ADDR_VRAM) begin
         res.offset = addr[OFFSET_W-1:0];
         if (op == OP_WRITE) begin
            res.target = TGT_BANK;
         end else if (addr < ADDR_ROMN) begin
            if (overlay_shadow && addr < ADDR_BOOT_EXIT) begin
               res.target = TGT_BOOT;
            end else begin
               if (addr == ADDR_BOOT_EXIT) overlay_shadow = 1'b0;
               res.target = TGT_ROM0;
            end
         end else begin
            res.target = TGT_ROMN;
            res.offset = {1'b0, addr[13:0]};
         end
      end else if (addr < ADDR_ERAM) begin
         res.target = TGT_VRAM;
         res.offset = {2'b00, addr[12:0]};
      end else if (addr < ADDR_WRAM) begin
         res.target = TGT_ERAM;
         res.offset = {2'b00, addr[12:0]};
      end else if (addr < ADDR_OAM) begin
         if (op == OP_WRITE) wram_shadow[addr[12:0]] = wdata;
         else res.data = wram_shadow[addr[12:0]];
      end else if (addr < ADDR_OAM_END) begin
         res.target = TGT_OAM;
         res.offset = OFFSET_W'(addr - ADDR_OAM);
      end else if (addr < ADDR_IO) begin
         // Unusable area: nothing to do.
      end else if (addr < ADDR_HRAM) begin
         if (addr == ADDR_IF) begin
            if (op == OP_WRITE) irq_flags_shadow = wdata;
            else res.data = irq_flags_shadow;
         end else if (addr >= ADDR_VIO_LO && addr < ADDR_VIO_HI) begin
            res.target = TGT_VIO;
            res.offset = OFFSET_W'(addr - ADDR_VIO_LO);
         end
      end else if (addr < ADDR_IE) begin
         hidx = addr[6:0];
         if (int'(hidx) < HRAM_BYTES) begin
            if (op == OP_WRITE) hram_shadow[hidx] = wdata;
            else res.data = hram_shadow[hidx];
         end
      end else begin
         if (op == OP_WRITE) irq_enable_shadow = wdata;
         else res.data = irq_enable_shadow;
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("Mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   always @(posedge clock) begin : check_results
      bus_result_type      want;
      logic [TARGET_W-1:0] got_target;
      logic [OFFSET_W-1:0] got_offset;
      logic [BYTE_W-1:0]   got_data;
      logic                got_write;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_target = rsp_tdata[3:0];
         got_offset = rsp_tdata[18:4];
         got_data   = rsp_tdata[26:19];
         got_write  = rsp_tuser[0];
         results_seen++;
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("unexpected item target %0d offset %h data %h write %b",
                                    got_target, got_offset, got_data, got_write));
         end else begin
            want = pending_results.pop_front();
            if (got_target !== want.target || got_offset !== want.offset ||
                got_data !== want.data || got_write !== want.is_write)
               note_mismatch($sformatf(
                  "addr %h: want tgt %0d off %h data %h wr %b, got tgt %0d off %h data %h wr %b",
                  want.address, want.target, want.offset, want.data, want.is_write,
                  got_target, got_offset, got_data, got_write));
         end
      end
   end

   // Presents one item and returns at the edge where it is taken; valid stays high.
   task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] wdata);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {wdata, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_READ && overlay_shadow && addr < ADDR_BOOT_EXIT) boot_reads++;
      pending_results.push_back(decode_access(op, addr, wdata));
      if (op == OP_WRITE) writes_sent++;
      else reads_sent++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Biased toward local storage and the I/O page so that reads see stored bytes.
   function automatic logic [ADDR_W-1:0] pick_address();
      int          sel;
      logic [12:0] widx;
      sel = $urandom_range(99);
      widx = 13'($urandom_range(31)) | ($urandom_range(1) ? 13'h1DE0 : 13'h0000);
      if (sel < 15) return ADDR_W'($urandom_range(16'hFFFF));
      if (sel < 40) return ($urandom_range(1) ? ADDR_ECHO : ADDR_WRAM) + {3'b000, widx};
      if (sel < 60) return ADDR_IO + ADDR_W'($urandom_range(255));
      if (sel < 70) return $urandom_range(1) ? ADDR_IF : ADDR_IE;
      if (sel < 80) return ADDR_W'($urandom_range(16'h7FFF));
      return ADDR_W'($urandom_range(16'hFEFF, 16'h8000));
   endfunction

   task automatic test_reset_values();
      send_access(OP_READ, 16'h0000, 8'h00);
      send_access(OP_READ, 16'hDFFF, 8'hFF);
      send_access(OP_READ, ADDR_HRAM, 8'h00);
      send_access(OP_READ, ADDR_IF, 8'h00);
      send_access(OP_READ, ADDR_IE, 8'h00);
   endtask

   task automatic test_region_edges();
      send_access(OP_WRITE, 16'h7FFF, 8'hFF);
      send_access(OP_READ,  16'h3FFF, 8'h00);
      send_access(OP_READ,  ADDR_ROMN, 8'h00);
      send_access(OP_READ,  16'h7FFF, 8'h00);
      send_access(OP_WRITE, ADDR_VRAM, 8'h00);
      send_access(OP_READ,  16'h9FFF, 8'h00);
      send_access(OP_WRITE, 16'hBFFF, 8'h81);
      // The top of the echo area aliases work RAM just below 0xDE00.
      send_access(OP_WRITE, 16'hFDFF, 8'hA5);
      send_access(OP_READ,  16'hDDFF, 8'h00);
      send_access(OP_WRITE, 16'hFE9F, 8'h3C);
      send_access(OP_WRITE, ADDR_OAM_END, 8'h55);
      send_access(OP_READ,  16'hFEFF, 8'h00);
      send_access(OP_WRITE, ADDR_IF, 8'hFF);
      send_access(OP_READ,  ADDR_IF, 8'h00);
      send_access(OP_WRITE, 16'hFF4B, 8'h12);
      send_access(OP_READ,  ADDR_VIO_HI, 8'h00);
      send_access(OP_WRITE, 16'hFFFE, 8'hC3);
      send_access(OP_READ,  16'hFFFE, 8'h00);
      send_access(OP_WRITE, ADDR_IE, 8'h7E);
      send_access(OP_READ,  ADDR_IE, 8'h00);
   endtask

   task automatic test_boot_overlay();
      send_access(OP_READ,  16'h00FF, 8'h00);
      // A write to the exit address goes to bank control and keeps the overlay.
      send_access(OP_WRITE, ADDR_BOOT_EXIT, 8'h01);
      send_access(OP_READ,  16'h0080, 8'h00);
      send_access(OP_READ,  ADDR_BOOT_EXIT, 8'h00);
      send_access(OP_READ,  16'h0000, 8'h00);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count, input bit pause_midway);
      logic              op;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] last_addr;
      logic              last_write;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      last_write = 1'b0;
      last_addr  = '0;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) wait_for_drain();
         if (last_write && $urandom_range(99) < 40) begin
            op   = OP_READ;
            addr = last_addr;
         end else begin
            op   = logic'($urandom_range(1));
            addr = pick_address();
         end
         send_access(op, addr, BYTE_W'($urandom_range(255)));
         last_write = (op == OP_WRITE);
         last_addr  = addr;
      end
   endtask

   initial begin
      for (int i = 0; i < WRAM_BYTES; i++) wram_shadow[i] = '0;
      for (int i = 0; i < 128; i++) hram_shadow[i] = '0;
      irq_enable_shadow = '0;
      irq_flags_shadow  = '0;
      overlay_shadow    = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_region_edges();
      test_boot_overlay();
      test_random_traffic(0, 0, PHASE_ITEMS, 1'b0);
      test_random_traffic(65, 0, PHASE_ITEMS, 1'b1);
      test_random_traffic(0, 65, PHASE_ITEMS, 1'b0);
      test_random_traffic(10, 10, PHASE_ITEMS, 1'b1);

      wait_for_drain();
      repeat (SETTLE) @(posedge clock);

      $display("Checked %0d result items against %0d reads and %0d writes, %0d mismatches.",
               results_seen, reads_sent, writes_sent, mismatch_count);
      $display("Covered every map region, %0d boot overlay reads, echo aliasing, %s",
               boot_reads, "and four pacing phases of sender gaps and receiver stalls.");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/cmmd_pkg.sv
rtl/cmmd_front.sv
rtl/cmmd_queue.sv
rtl/cmmd_back.sv
rtl/console_memory_map_decoder_core.sv
sim/tb_console_memory_map_decoder_core.sv
